// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, reset values and codes of the block bump allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF  = 32;
  localparam int unsigned OFFSET_BITS_DEF = 26;

  localparam int unsigned SIZE_W   = 27;
  localparam int unsigned ALIGN_W  = 4;
  localparam int unsigned ID_W     = 5;
  localparam int unsigned OFF_W    = 26;
  localparam int unsigned STATUS_W = 2;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 27'd67108864;

  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [ALIGN_W-1:0]  align_t;
  typedef logic [ID_W-1:0]     block_id_t;
  typedef logic [OFF_W-1:0]    offset_t;
  typedef logic [STATUS_W-1:0] status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_BIG  = 2'd1,
    STATUS_NO_BLOCK = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bba_req_if;
  import bba_pkg::*;

  logic   valid;
  logic   ready;
  logic   req_type;
  size_t  alloc_size;
  align_t align_log2;

  modport source (output valid, output req_type, output alloc_size, output align_log2,
                  input ready);
  modport sink   (input valid, input req_type, input alloc_size, input align_log2,
                  output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;

  logic      valid;
  logic      ready;
  block_id_t block_id;
  offset_t   offset;
  status_t   status;

  modport source (output valid, output block_id, output offset, output status,
                  input ready);
  modport sink   (input valid, input block_id, input offset, input status,
                  output ready);
endinterface

// ===== hw/rtl/block_bump_allocator_top.sv =====
// ----------------------------------------------------------------------------
// block_bump_allocator_top
// Bump allocator over a pool of equal blocks with a free stack and used list.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     word
//  -------  ---  ------------  ------------------------------------------
//  req_i    in   valid/ready   req_type, alloc_size, align_log2
//  rsp_o    out  valid/ready   block_id, offset, status
//  cfg      in   cfg_we_i      cfg_wdata_i -> block_size (no read-back)
//
//  Steps: one shared adder/comparator steps an allocate through size check,
//  alignment and fit check; an oversized request ends after the size check. A
//  clear moves the used blocks back one at a time through the used-list read
//  port, alternating between S_CLR and S_CLW for each block.
//  Reset: asynchronous, active low; the free stack is preset by per-entry
//  valid bits, so no sweep is needed and req_i is ready right after reset.
//  Stalls: req_i is taken only in idle; a new word may be taken while the last
//  result waits on rsp_o, and the last step then holds until rsp_o drains.
// ----------------------------------------------------------------------------
module block_bump_allocator_top #(
  parameter int unsigned NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned OFFSET_BITS = bba_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::SIZE_W-1:0] cfg_wdata_i,
  bba_req_if.sink                   req_i,
  bba_rsp_if.source                 rsp_o
);
  import bba_pkg::*;

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  // arithmetic width: holds size + mask and offsets up to 2^OFFSET_BITS
  localparam int unsigned AW = ((OFFSET_BITS + 1 > SIZE_W) ? OFFSET_BITS + 1 : SIZE_W) + 1;
  localparam logic [AW-1:0] CAP = AW'(1) << OFFSET_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_ALN  = 6'b000100,
    S_FIT  = 6'b001000,
    S_CLR  = 6'b010000,
    S_CLW  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  size_t             block_size_q;
  size_t             size_q, size_d;
  align_t            alog_q, alog_d;
  logic [AW-1:0]     aligned_q, aligned_d;
  logic [AW-1:0]     bump_q, bump_d;
  logic              cur_valid_q, cur_valid_d;
  logic [IDX_W-1:0]  cur_block_q, cur_block_d;
  logic [CNT_W-1:0]  free_count_q, free_count_d;
  logic [CNT_W-1:0]  used_count_q, used_count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;

  // stores
  logic [IDX_W-1:0]      fs_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] fs_valid_q;
  logic [IDX_W-1:0]      ul_mem [NUM_BLOCKS];
  logic [IDX_W-1:0]      fs_rdata_q, fs_ridx_q, ul_rdata_q;
  logic                  fs_rvalid_q;
  logic [IDX_W-1:0]      fs_raddr, pop_blk;
  logic                  fs_we, ul_we;

  // shared unit
  logic [AW-1:0] bs_ext, bs_eff, mask, op_a, op_b, sum;
  logic          over;

  // result
  logic          res_valid;
  block_id_t     res_id;
  offset_t       res_off;
  status_e       res_status;
  logic          out_free;
  logic          rsp_valid_q;
  block_id_t     rsp_id_q;
  offset_t       rsp_off_q;
  status_t       rsp_status_q;

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.block_id = rsp_id_q;
  assign rsp_o.offset   = rsp_off_q;
  assign rsp_o.status   = rsp_status_q;
  assign out_free       = !rsp_valid_q || rsp_o.ready;

  // block size clamps at 2^OFFSET_BITS
  assign bs_ext = AW'(block_size_q);
  assign bs_eff = (bs_ext > CAP) ? CAP : bs_ext;
  assign mask   = (AW'(1) << alog_q) - AW'(1);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_CHK: begin
        op_a = AW'(size_q);
        op_b = mask;
      end
      S_ALN: begin
        op_a = bump_q;
        op_b = mask;
      end
      S_FIT: begin
        op_a = aligned_q;
        op_b = AW'(size_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum  = op_a + op_b;
  assign over = sum > bs_eff;

  // top of free stack; entries never written read as their own index
  assign fs_raddr = IDX_W'(free_count_q - CNT_W'(1));
  assign pop_blk  = fs_rvalid_q ? fs_rdata_q : fs_ridx_q;

  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    alog_d       = alog_q;
    aligned_d    = aligned_q;
    bump_d       = bump_q;
    cur_valid_d  = cur_valid_q;
    cur_block_d  = cur_block_q;
    free_count_d = free_count_q;
    used_count_d = used_count_q;
    idx_d        = idx_q;
    res_valid    = 1'b0;
    res_id       = '0;
    res_off      = '0;
    res_status   = STATUS_OK;
    fs_we        = 1'b0;
    ul_we        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          size_d  = req_i.alloc_size;
          alog_d  = req_i.align_log2;
          idx_d   = '0;
          state_d = (req_i.req_type == REQ_CLEAR) ? S_CLR : S_CHK;
        end
      end
      S_CHK: begin
        if (over) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res_status = STATUS_TOO_BIG;
            state_d    = S_IDLE;
          end
        end else begin
          state_d = S_ALN;
        end
      end
      S_ALN: begin
        aligned_d = sum & ~mask;
        state_d   = S_FIT;
      end
      S_FIT: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_d   = S_IDLE;
          if (cur_valid_q && !over && (aligned_q < CAP)) begin
            bump_d  = sum;
            res_id  = ID_W'(cur_block_q);
            res_off = OFF_W'(aligned_q);
          end else if (free_count_q == '0) begin
            res_status = STATUS_NO_BLOCK;
          end else begin
            // take a fresh block, allocation starts at offset 0
            ul_we        = 1'b1;
            cur_block_d  = pop_blk;
            cur_valid_d  = 1'b1;
            free_count_d = free_count_q - CNT_W'(1);
            used_count_d = used_count_q + CNT_W'(1);
            bump_d       = AW'(size_q);
            res_id       = ID_W'(pop_blk);
          end
        end
      end
      S_CLR: begin
        if (idx_q == used_count_q) begin
          if (out_free) begin
            res_valid    = 1'b1;
            used_count_d = '0;
            cur_valid_d  = 1'b0;
            bump_d       = '0;
            state_d      = S_IDLE;
          end
        end else begin
          state_d = S_CLW;
        end
      end
      S_CLW: begin
        fs_we        = 1'b1;
        free_count_d = free_count_q + CNT_W'(1);
        idx_d        = idx_q + CNT_W'(1);
        state_d      = S_CLR;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      block_size_q <= BLOCK_SIZE_RST;
      bump_q       <= '0;
      cur_valid_q  <= 1'b0;
      cur_block_q  <= '0;
      free_count_q <= CNT_W'(NUM_BLOCKS);
      used_count_q <= '0;
      idx_q        <= '0;
      fs_valid_q   <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bump_q       <= bump_d;
      cur_valid_q  <= cur_valid_d;
      cur_block_q  <= cur_block_d;
      free_count_q <= free_count_d;
      used_count_q <= used_count_d;
      idx_q        <= idx_d;
      if (cfg_we_i) begin
        block_size_q <= cfg_wdata_i;
      end
      if (fs_we) begin
        fs_valid_q[IDX_W'(free_count_q)] <= 1'b1;
      end
      if (res_valid) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q    <= size_d;
    alog_q    <= alog_d;
    aligned_q <= aligned_d;
    if (res_valid) begin
      rsp_id_q     <= res_id;
      rsp_off_q    <= res_off;
      rsp_status_q <= res_status;
    end
  end

  // free stack memory, registered read of the top entry
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[IDX_W'(free_count_q)] <= ul_rdata_q;
    end
    fs_rdata_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i) begin
    fs_rvalid_q <= fs_valid_q[fs_raddr];
    fs_ridx_q   <= fs_raddr;
  end

  // used list memory, read walks it during a clear
  always_ff @(posedge clk_i) begin
    if (ul_we) begin
      ul_mem[IDX_W'(used_count_q)] <= pop_blk;
    end
    ul_rdata_q <= ul_mem[IDX_W'(idx_q)];
  end

endmodule

// ===== hw/rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the block bump allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [bba_pkg::ID_W-1:0]     rsp_block_id_i,
  input logic [bba_pkg::OFF_W-1:0]    rsp_offset_i,
  input logic [bba_pkg::STATUS_W-1:0] rsp_status_i
);
  import bba_pkg::*;

  // stalled result word stays up
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_block_id_i) && $stable(rsp_offset_i) && $stable(rsp_status_i))
    else $error("result changed while stalled");

  // failed requests carry no block or offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |->
      (rsp_block_id_i == '0) && (rsp_offset_i == '0))
    else $error("failed request with nonzero block or offset");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == STATUS_OK) || (rsp_status_i == STATUS_TOO_BIG) ||
                    (rsp_status_i == STATUS_NO_BLOCK))
    else $error("reserved status code");

  // every request keeps the sequencer busy, so req_i is not ready in the cycle after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready right after accepting a request");

endmodule

bind block_bump_allocator_top bba_checker u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_block_id_i (rsp_o.block_id),
  .rsp_offset_i   (rsp_o.offset),
  .rsp_status_i   (rsp_o.status)
);
